FILE: rtl/core/adb_controller_handshake_macros.svh
// Assertion helpers used by the checker module.
`ifndef ADB_CONTROLLER_HANDSHAKE_MACROS_SVH
`define ADB_CONTROLLER_HANDSHAKE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ADB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ADB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/adb_hs_pkg.sv
package adb_hs_pkg;

  // Receive count saturates at this many bytes.
  localparam int RECV_DEPTH = 16;
  localparam int IDX_W      = $clog2(RECV_DEPTH + 1);

  localparam logic [7:0] PKT_BUS      = 8'h00;
  localparam logic [7:0] CMD_PACKET   = 8'h01;
  localparam logic [7:0] CMD_AUTOPOLL = 8'h01;
  localparam logic [7:0] AP_ENABLE    = 8'h01;
  localparam logic [7:0] AP_DISABLE   = 8'h00;
  localparam logic [1:0] REG_NUM_ZERO = 2'b00;

  // Byte positions and lengths on the byte counter.
  localparam logic [IDX_W-1:0] IDX_TYPE    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_HEADER  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_DATA_HI = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_DATA_LO = IDX_W'(4);
  localparam logic [IDX_W-1:0] PKT_MIN_LEN = IDX_W'(2);
  localparam logic [IDX_W-1:0] RPT_LEN     = IDX_W'(5);
  localparam logic [IDX_W-1:0] CMD_LEN     = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LIMIT   = IDX_W'(RECV_DEPTH);

  typedef enum logic [2:0] {
    ST_LISTEN     = 3'd0,
    ST_RECEIVE    = 3'd1,
    ST_RCV_END    = 3'd2,
    ST_SEND_START = 3'd3,
    ST_SEND       = 3'd4
  } state_t;

  typedef struct packed {
    logic       kind;
    logic       req;
    logic [7:0] sbyte;
    logic       ap;
  } evt_t;

  typedef struct packed {
    logic        tip;
    logic        tack;
    logic        dir_out;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        collision;
    logic        report_valid;
    logic [3:0]  report_address;
    logic [15:0] report_value;
    logic        bad_packet;
  } res_t;

endpackage

FILE: rtl/core/adb_hs_fsm.sv
module adb_hs_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  adb_hs_pkg::evt_t ev,
  output adb_hs_pkg::res_t res
);
  import adb_hs_pkg::*;

  state_t           st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             ap_r, ap_nxt;
  logic             tip_r, tip_nxt;
  logic             tack_r, tack_nxt;
  logic             dir_r, dir_nxt;
  logic [7:0]       pkt0_r, pkt0_nxt;
  logic [7:0]       pkt2_r, pkt2_nxt;
  logic [7:0]       pkt3_r, pkt3_nxt;
  logic [7:0]       pkt4_r, pkt4_nxt;

  // Next state
  always_comb begin
    st_nxt = st_r;
    if (step) begin
      if (ev.kind) begin
        if (st_r == ST_LISTEN && ev.req) st_nxt = ST_SEND_START;
      end else begin
        case (st_r)
          ST_LISTEN:     if (!ev.req) st_nxt = ST_RECEIVE;
          ST_RECEIVE:    if (ev.req) st_nxt = ST_RCV_END;
          ST_RCV_END: begin
            if (!ev.req)     st_nxt = ST_RECEIVE;
            else if (pend_r) st_nxt = ST_SEND_START;
            else             st_nxt = ST_LISTEN;
          end
          ST_SEND_START: st_nxt = ev.req ? ST_SEND : ST_LISTEN;
          ST_SEND:       if (!(pend_r && idx_r < CMD_LEN)) st_nxt = ST_LISTEN;
          default:       st_nxt = ST_LISTEN;
        endcase
      end
    end
  end

  // Line levels, buffers and result word
  always_comb begin
    idx_nxt  = idx_r;
    pend_nxt = pend_r;
    ap_nxt   = ap_r;
    tip_nxt  = tip_r;
    tack_nxt = tack_r;
    dir_nxt  = dir_r;
    pkt0_nxt = pkt0_r;
    pkt2_nxt = pkt2_r;
    pkt3_nxt = pkt3_r;
    pkt4_nxt = pkt4_r;
    res      = '0;
    if (step) begin
      if (ev.kind) begin
        if (st_r == ST_LISTEN) begin
          pend_nxt = 1'b1;
          ap_nxt   = ev.ap;
          idx_nxt  = '0;
          if (ev.req) begin
            dir_nxt        = 1'b1;
            res.send_valid = 1'b1;
            res.send_byte  = CMD_PACKET;
            tip_nxt        = 1'b0;
          end
        end
      end else begin
        case (st_r)
          ST_LISTEN: if (!ev.req) tip_nxt = 1'b0;
          ST_RECEIVE: begin
            if (idx_r < IDX_LIMIT) begin
              if (idx_r == IDX_TYPE)    pkt0_nxt = ev.sbyte;
              if (idx_r == IDX_HEADER)  pkt2_nxt = ev.sbyte;
              if (idx_r == IDX_DATA_HI) pkt3_nxt = ev.sbyte;
              if (idx_r == IDX_DATA_LO) pkt4_nxt = ev.sbyte;
              idx_nxt = idx_r + IDX_W'(1);
            end
            if (!ev.req) begin
              tack_nxt = ~tack_r;
            end else begin
              tack_nxt = 1'b1;
              tip_nxt  = 1'b1;
            end
          end
          ST_RCV_END: begin
            if (!ev.req) begin
              tip_nxt = 1'b0;
            end else if (pend_r) begin
              dir_nxt        = 1'b1;
              res.send_valid = 1'b1;
              res.send_byte  = CMD_PACKET;
              tip_nxt        = 1'b0;
            end
            idx_nxt = '0;
            if (idx_r >= PKT_MIN_LEN && pkt0_r == PKT_BUS) begin
              if (idx_r == RPT_LEN && pkt2_r[1:0] == REG_NUM_ZERO) begin
                res.report_valid   = 1'b1;
                res.report_address = pkt2_r[7:4];
                res.report_value   = {pkt3_r, pkt4_r};
              end else begin
                res.bad_packet = 1'b1;
              end
            end
          end
          ST_SEND_START: begin
            if (!ev.req) begin
              dir_nxt       = 1'b0;
              tip_nxt       = 1'b1;
              tack_nxt      = 1'b1;
              res.collision = 1'b1;
            end else begin
              res.send_valid = 1'b1;
              res.send_byte  = CMD_AUTOPOLL;
              tack_nxt       = ~tack_r;
              idx_nxt        = IDX_HEADER;
            end
          end
          ST_SEND: begin
            if (pend_r && idx_r < CMD_LEN) begin
              res.send_valid = 1'b1;
              if (idx_r == IDX_HEADER) res.send_byte = ap_r ? AP_ENABLE : AP_DISABLE;
              else                     res.send_byte = CMD_AUTOPOLL;
              idx_nxt  = idx_r + IDX_W'(1);
              tack_nxt = ~tack_r;
            end else begin
              pend_nxt = 1'b0;
              idx_nxt  = '0;
              dir_nxt  = 1'b0;
              tack_nxt = 1'b1;
              tip_nxt  = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    res.tip     = tip_nxt;
    res.tack    = tack_nxt;
    res.dir_out = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_LISTEN;
      idx_r  <= '0;
      pend_r <= 1'b0;
      tip_r  <= 1'b1;
      tack_r <= 1'b1;
      dir_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
      tip_r  <= tip_nxt;
      tack_r <= tack_nxt;
      dir_r  <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ap_r   <= ap_nxt;
    pkt0_r <= pkt0_nxt;
    pkt2_r <= pkt2_nxt;
    pkt3_r <= pkt3_nxt;
    pkt4_r <= pkt4_nxt;
  end

endmodule

FILE: rtl/core/adb_controller_handshake.sv
// Host-side handshake engine for a desktop-bus microcontroller. Each input word is one
// event (shift interrupt or autopoll send request) and yields exactly one result word
// with the driven line levels, any byte to load into the shift register, and any
// collision, register-0 report or bad-packet flag. An event is registered on entry,
// decided combinationally by the transfer state machine and registered again on exit;
// a new word is taken every cycle while in_stall is low, and in_stall rises only when
// the output register is full and out_stall holds it.
module adb_controller_handshake (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic        in_request_line,
  input  logic [7:0]  in_shift_byte,
  input  logic        in_autopoll_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_in_progress_line,
  output logic        out_ack_line,
  output logic        out_shift_direction_out,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic        out_collision,
  output logic        out_report_valid,
  output logic [3:0]  out_report_address,
  output logic [15:0] out_report_value,
  output logic        out_bad_packet
);
  import adb_hs_pkg::*;

  logic in_vld_r, in_vld_nxt;
  evt_t in_r;
  logic out_vld_r, out_vld_nxt;
  res_t out_r;
  res_t res;
  logic adv;
  logic in_acc;

  assign adv      = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~adv;
  assign in_acc   = in_valid & ~in_stall;

  assign in_vld_nxt  = in_acc | (in_vld_r & ~adv);
  assign out_vld_nxt = adv | (out_vld_r & out_stall);

  adb_hs_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .ev    (in_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= '{kind: in_kind, req: in_request_line, sbyte: in_shift_byte,
                ap: in_autopoll_on};
    end
    if (adv) out_r <= res;
  end

  assign out_valid               = out_vld_r;
  assign out_in_progress_line    = out_r.tip;
  assign out_ack_line            = out_r.tack;
  assign out_shift_direction_out = out_r.dir_out;
  assign out_send_valid          = out_r.send_valid;
  assign out_send_byte           = out_r.send_byte;
  assign out_collision           = out_r.collision;
  assign out_report_valid        = out_r.report_valid;
  assign out_report_address      = out_r.report_address;
  assign out_report_value        = out_r.report_value;
  assign out_bad_packet          = out_r.bad_packet;

endmodule

FILE: rtl/core/adb_hs_checker.sv
`include "adb_controller_handshake_macros.svh"

module adb_hs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_in_progress_line,
  input logic        out_shift_direction_out,
  input logic        out_send_valid,
  input logic [7:0]  out_send_byte,
  input logic        out_collision,
  input logic        out_report_valid,
  input logic [3:0]  out_report_address,
  input logic [15:0] out_report_value,
  input logic        out_bad_packet
);

  `ADB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_send_byte) && $stable(out_report_value), "stalled result word changed")
  `ADB_ASSERT_IMP(a_idle_byte, out_valid && !out_send_valid, out_send_byte == 8'h00, "send byte set without send_valid")
  `ADB_ASSERT_IMP(a_send_dir, out_valid && out_send_valid, out_shift_direction_out, "byte sent with shift register as input")
  `ADB_ASSERT_IMP(a_collision, out_valid && out_collision, !out_send_valid && !out_shift_direction_out && out_in_progress_line, "collision left the bus driven")
  `ADB_ASSERT_IMP(a_report, out_valid && !out_report_valid, out_report_address == 4'h0 && out_report_value == 16'h0000 || out_bad_packet && out_report_value == 16'h0000, "report fields set without report_valid")

endmodule

bind adb_controller_handshake adb_hs_checker u_adb_hs_checker (.*);
